>>> sv/assert_macros.svh
// Assertion helpers used by the frame ring buffer datapath.
// Every macro samples on the rising edge of clk and is quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

>>> sv/frb_pkg.sv
// Shared types, constants and the watermark table of the frame ring buffer.
// Depends on nothing; every other RTL file of the block but frb_ram imports it.
package frb_pkg;

  // Ring geometry (field widths follow from the ring size)
  localparam int BUF_BYTES = 4194304;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int SUM_W     = ADDR_W + 2;

  // Descriptor FIFO default depth
  localparam int DESC_DEPTH_DEF = 64;

  // Timestamp fields
  localparam int SEC_W     = 32;
  localparam int MS_W      = 10;
  localparam int TIME_W    = 42;
  localparam int MS_PER_S  = 1000;

  // Configuration port
  localparam int PCT_W     = 7;
  localparam int PCT_CODES = 1 << PCT_W;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b1;
  localparam logic [PCT_W-1:0] UPPER_PCT_RST = 7'd80;
  localparam logic [PCT_W-1:0] LOWER_PCT_RST = 7'd20;

  // Watermark event codes
  localparam int EV_W = 2;
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_HIGH = 2'd1;
  localparam logic [EV_W-1:0] EV_LOW  = 2'd2;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Marks reach 127% of the ring, which still fits in a length word
  localparam int MARK_W = LEN_W;
  typedef logic [MARK_W-1:0] mark_t;
  typedef mark_t mark_tab_t [PCT_CODES];

  // mark = floor(ring size * percent / 100), built at elaboration
  function automatic mark_tab_t build_marks();
    mark_tab_t tab;
    for (int p = 0; p < PCT_CODES; p++) begin
      tab[p] = MARK_W'((longint'(BUF_BYTES) * longint'(p)) / 100);
    end
    return tab;
  endfunction

  localparam mark_tab_t MARK_TABLE = build_marks();

  // Input request
  typedef struct packed {
    logic              action;
    logic [LEN_W-1:0]  payload_len;
    logic [SEC_W-1:0]  stamp_seconds;
    logic [MS_W-1:0]   stamp_millis;
    logic              status_normal;
  } in_item_t;

  // Result
  typedef struct packed {
    logic              done_res;
    logic [ADDR_W-1:0] start_addr;
    logic [LEN_W-1:0]  first_len;
    logic [LEN_W-1:0]  second_len;
    logic              popped_normal;
    logic [TIME_W-1:0] curr_time_ms;
    logic [TIME_W-1:0] next_time_ms;
    logic              paused;
    logic [EV_W-1:0]   mark_event;
  } out_item_t;

  // One descriptor FIFO entry
  typedef struct packed {
    logic [ADDR_W-1:0] location;
    logic [LEN_W-1:0]  length;
    logic [SEC_W-1:0]  seconds;
    logic [MS_W-1:0]   millis;
    logic              normal;
  } desc_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic wr_commit;  // reserve space, push descriptor, load result
    logic load_zero;  // load a rejected / empty result
    logic rd_pop;     // pop head descriptor, start its time product
    logic rd_peek;    // next descriptor arrives, finish current time
    logic rd_finish;  // load the read result
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_read;
    logic wr_fits;
    logic q_empty;
    logic out_free;
  } stat_t;

endpackage

>>> sv/frb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the descriptor FIFO storage.
module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/frb_ctrl.sv
// Sequencing state machine of the frame ring buffer.
// Depends on frb_pkg for the command and status structs.
module frb_ctrl
  import frb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_PEEK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_read && !stat.q_empty) begin
          // pop does not touch the result register, so it never waits
          cmd.rd_pop = 1'b1;
          state_next = S_PEEK;
        end else if (stat.out_free) begin
          if (!stat.is_read && stat.wr_fits) begin
            cmd.wr_commit = 1'b1;
          end else begin
            cmd.load_zero = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_PEEK: begin
        cmd.rd_peek = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.rd_finish = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/frb_dp.sv
// Datapath of the frame ring buffer: ring pointers, occupancy, watermarks,
// descriptor FIFO and result register. Depends on frb_pkg and frb_ram.
`include "assert_macros.svh"

module frb_dp
  import frb_pkg::*;
#(
  parameter int DESC_DEPTH = DESC_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  localparam int PTR_W = $clog2(DESC_DEPTH);
  localparam int CNT_W = $clog2(DESC_DEPTH + 1);

  // control state
  mark_t             mark_hi;
  mark_t             mark_lo;
  logic [LEN_W-1:0]  occ;
  logic [ADDR_W-1:0] wp;
  logic              thr;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  count;

  // payload registers
  in_item_t          in_reg;
  logic [ADDR_W-1:0] res_start;
  logic [LEN_W-1:0]  res_first;
  logic [LEN_W-1:0]  res_second;
  logic              res_pnorm;
  logic [EV_W-1:0]   ev_reg;
  logic [TIME_W-1:0] prod;
  logic [MS_W-1:0]   ms_reg;
  logic [TIME_W-1:0] cur_time;
  logic              nnorm;

  // descriptor memory
  logic [$bits(desc_t)-1:0] rd_bits;
  desc_t             rd_desc;
  desc_t             wr_desc;
  logic [PTR_W-1:0]  raddr;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;

  // write math
  logic [SUM_W-1:0]  wr_sum;
  logic              wr_fits;
  logic [SUM_W-1:0]  wr_end;
  logic              wr_wrap;
  logic [LEN_W-1:0]  wr_first;
  logic [LEN_W-1:0]  wr_second;
  logic [SUM_W-1:0]  wp_raw;
  logic [ADDR_W-1:0] wp_next;
  logic [LEN_W-1:0]  occ_wr;
  logic              hit_hi;

  // read math
  logic [SUM_W-1:0]  rd_end;
  logic              rd_wrap;
  logic [LEN_W-1:0]  rd_first;
  logic [LEN_W-1:0]  rd_second;
  logic [LEN_W-1:0]  occ_rd;
  logic              hit_lo;
  logic [TIME_W-1:0] prod_in;
  logic [TIME_W-1:0] next_time;

  out_item_t         out_next;
  logic              out_load;

  // FIFO index stepping with wrap at the depth
  assign head_inc = (head == PTR_W'(DESC_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PTR_W'(DESC_DEPTH - 1)) ? '0 : tail + 1'b1;

  // head is read all the time; the pop cycle looks one entry ahead
  assign raddr = cmd.rd_pop ? head_inc : head;

  assign wr_desc = '{location: wp,
                     length:   in_reg.payload_len,
                     seconds:  in_reg.stamp_seconds,
                     millis:   in_reg.stamp_millis,
                     normal:   in_reg.status_normal};

  frb_ram #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (cmd.wr_commit),
    .waddr (tail),
    .wdata (wr_desc),
    .raddr (raddr),
    .rdata (rd_bits)
  );

  assign rd_desc = desc_t'(rd_bits);

  // write: admission, split at ring end, pointer advance, high mark
  always_comb begin
    wr_sum    = SUM_W'(occ) + SUM_W'(in_reg.payload_len);
    wr_fits   = (wr_sum < SUM_W'(BUF_BYTES)) && (count < CNT_W'(DESC_DEPTH));
    wr_end    = SUM_W'(wp) + SUM_W'(in_reg.payload_len);
    wr_wrap   = wr_end > SUM_W'(BUF_BYTES);
    wr_first  = wr_wrap ? LEN_W'(BUF_BYTES) - LEN_W'(wp) : in_reg.payload_len;
    wr_second = wr_wrap ? in_reg.payload_len - wr_first : '0;
    wp_raw    = wr_wrap ? SUM_W'(wr_second) : wr_end;
    // landing exactly on the ring end folds back to address zero
    wp_next   = (wp_raw >= SUM_W'(BUF_BYTES)) ? '0 : wp_raw[ADDR_W-1:0];
    occ_wr    = wr_sum[LEN_W-1:0];
    hit_hi    = (occ_wr >= mark_hi) && !thr;
  end

  // read: split of the popped frame, occupancy release, low mark
  always_comb begin
    rd_end    = SUM_W'(rd_desc.location) + SUM_W'(rd_desc.length);
    // location is always inside the ring, so only the end is checked
    rd_wrap   = rd_end > SUM_W'(BUF_BYTES);
    rd_first  = rd_wrap ? LEN_W'(BUF_BYTES) - LEN_W'(rd_desc.location) : rd_desc.length;
    rd_second = rd_wrap ? rd_desc.length - rd_first : '0;
    occ_rd    = (occ >= rd_desc.length) ? occ - rd_desc.length : '0;
    hit_lo    = (occ_rd <= mark_lo) && thr;
  end

  // seconds to milliseconds; the product is registered before the add
  assign prod_in = TIME_W'(rd_desc.seconds) * TIME_W'(MS_PER_S);

  // next frame time only for a queued frame with normal status
  assign next_time = ((count != '0) && nnorm) ? prod + TIME_W'(ms_reg) : cur_time;

  // result assembly
  always_comb begin
    out_next        = '0;
    out_next.paused = thr;
    out_load        = 1'b0;
    if (cmd.wr_commit) begin
      out_load            = 1'b1;
      out_next.done_res   = 1'b1;
      out_next.start_addr = wp;
      out_next.first_len  = wr_first;
      out_next.second_len = wr_second;
      out_next.paused     = thr | hit_hi;
      out_next.mark_event = hit_hi ? EV_HIGH : EV_NONE;
    end else if (cmd.rd_finish) begin
      out_load               = 1'b1;
      out_next.done_res      = 1'b1;
      out_next.start_addr    = res_start;
      out_next.first_len     = res_first;
      out_next.second_len    = res_second;
      out_next.popped_normal = res_pnorm;
      out_next.curr_time_ms  = cur_time;
      out_next.next_time_ms  = next_time;
      out_next.mark_event    = ev_reg;
    end else if (cmd.load_zero) begin
      out_load = 1'b1;
    end
  end

  assign stat = '{is_read:  in_reg.action == ACT_READ,
                  wr_fits:  wr_fits,
                  q_empty:  count == '0,
                  out_free: !out_valid || out_ready};

  // control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_hi   <= MARK_TABLE[UPPER_PCT_RST];
      mark_lo   <= MARK_TABLE[LOWER_PCT_RST];
      occ       <= '0;
      wp        <= '0;
      thr       <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UPPER: mark_hi <= MARK_TABLE[cfg_data];
          REG_LOWER: mark_lo <= MARK_TABLE[cfg_data];
          default: ;
        endcase
      end
      if (cmd.wr_commit) begin
        tail  <= tail_inc;
        count <= count + 1'b1;
        wp    <= wp_next;
        occ   <= occ_wr;
        if (hit_hi) begin
          thr <= 1'b1;
        end
      end
      if (cmd.rd_pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
        occ   <= occ_rd;
        if (hit_lo) begin
          thr <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_reg <= in_item;
    end
    if (cmd.rd_pop) begin
      res_start  <= rd_desc.location;
      res_first  <= rd_first;
      res_second <= rd_second;
      res_pnorm  <= rd_desc.normal;
      ev_reg     <= hit_lo ? EV_LOW : EV_NONE;
      prod       <= prod_in;
      ms_reg     <= rd_desc.millis;
    end
    if (cmd.rd_peek) begin
      cur_time <= prod + TIME_W'(ms_reg);
      prod     <= prod_in;
      ms_reg   <= rd_desc.millis;
      nnorm    <= rd_desc.normal;
    end
    if (out_load) begin
      out_item <= out_next;
    end
  end

  // checks
  `ASSERT_CLK(a_occ_below_ring, occ < LEN_W'(BUF_BYTES), "occupancy reached ring size")
  `ASSERT_CLK(a_count_bound, count <= CNT_W'(DESC_DEPTH), "descriptor count over depth")
  `ASSERT_CLK(a_push_counts, cmd.wr_commit |=> count == $past(count) + 1'b1, "push lost")
  `ASSERT_CLK(a_empty_aligned, (count == '0) |-> (head == tail), "empty FIFO misaligned")

endmodule

>>> sv/frame_ring_buffer_watermark_core.sv
// Top level of the frame ring buffer with watermarks.
// Depends on frb_pkg, frb_ctrl, frb_dp (which holds frb_ram).
//
// Usage:
//   in_valid/in_ready/in_item carries one request: a write reserves ring
//   space and pushes a frame descriptor, a read pops the oldest one.
//   out_valid/out_ready/out_item returns exactly one result per request.
//   cfg_we/cfg_index/cfg_data set the high (index 0) and low (index 1)
//   watermark percentages; write them only while no request is in flight.
// Sequence:
//   A write is accepted, then executed with its result loaded; a read is
//   accepted, then pops, fetches the next descriptor and finishes times.
//   The read steps come from the single read port of the descriptor RAM:
//   the popped entry and the entry behind it are fetched one after the
//   other, and the seconds-to-ms multiply is registered. The result is
//   visible the cycle after its last step.
// Reset (rst, synchronous): ring and FIFO empty, pause flag low, marks at
//   80% and 20%. No clearing pass; descriptor RAM is used only once written.
// Stall: the result register holds until taken; a new request is accepted
//   meanwhile; its result waits for the register, though a read pops first.
module frame_ring_buffer_watermark_core
  import frb_pkg::*;
#(
  parameter int DESC_DEPTH = DESC_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  frb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bookkeeping and result register
  frb_dp #(
    .DESC_DEPTH (DESC_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
